@@ rtl/pmpu_pkg.sv @@
// shared types and constants of the power mode policy unit
package pmpu_pkg;

  typedef enum logic [1:0] {
    PWR_ACTIVE = 2'd0,
    PWR_IDLE   = 2'd1,
    PWR_SLEEP  = 2'd2
  } pwr_state_t;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_SQUARE,
    SEQ_MUL,
    SEQ_ACC
  } seq_state_t;

  localparam logic FUNC_RECORD = 1'b0;
  localparam logic FUNC_TICK   = 1'b1;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_LOW       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_HIGH      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_CONST      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_IDLE_LIN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_IDLE_SQ    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_ACTIVE_LIN = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_ACTIVE_SQ  = 3'd7;

  localparam logic [1:0] TERM_IDLE_LIN   = 2'd0;
  localparam logic [1:0] TERM_IDLE_SQ    = 2'd1;
  localparam logic [1:0] TERM_ACTIVE_LIN = 2'd2;
  localparam logic [1:0] TERM_ACTIVE_SQ  = 2'd3;

  localparam logic [4:0] CNT_NARROW_LAST = 5'd15;
  localparam logic [4:0] CNT_WIDE_LAST   = 5'd31;

endpackage

@@ rtl/pmpu_if.sv @@
// channel interfaces of the power mode policy unit
interface pmpu_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [31:0] idle_start;
  logic [31:0] idle_end;

  modport source (output valid, func, idle_start, idle_end, input ready);
  modport sink   (input valid, func, idle_start, idle_end, output ready);
endinterface

interface pmpu_out_if;
  logic                  valid;
  logic                  ready;
  pmpu_pkg::pwr_state_t  power_state;
  logic [31:0]           tick_time;
  logic                  state_changed;
  logic                  timeout_waiting;
  logic                  period_last;

  modport source (output valid, power_state, tick_time, state_changed, timeout_waiting,
                  period_last, input ready);
  modport sink   (input valid, power_state, tick_time, state_changed, timeout_waiting,
                  period_last, output ready);
endinterface

@@ rtl/power_mode_policy_unit.sv @@
// power mode policy unit: timeout and history predictive power state decisions
//
//  channel  | direction | transaction
//  ---------+-----------+------------------------------------------------------
//  in_ch    | sink      | func, idle_start, idle_end (period record or tick)
//  out_ch   | source    | power_state, tick_time, state_changed, timeout_waiting,
//           |           | period_last (one per tick before the period end)
//  cfg_*    | write     | cfg_wr_en, cfg_index, cfg_wdata
//
// a tick's decision is registered and sits in the output register until taken.
// a period record keeps the input stalled after acceptance: the two squares run
// side by side in bit-serial shift-add units, then one shared bit-serial
// multiplier runs each term, wider for the squared terms, plus one saturating add.
// in_ch.ready is low while the output register is full and not being taken.
// rst_n is synchronous; it clears policy state, config, sequencer and out valid only.
module power_mode_policy_unit #(
  parameter int HISTORY_DEPTH = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  pmpu_in_if.sink                        in_ch,
  pmpu_out_if.source                     out_ch,
  input  logic                           cfg_wr_en,
  input  logic [pmpu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_wdata
);

  // configuration
  logic        policy_mode_r;
  logic [15:0] level_low_r;
  logic [15:0] level_high_r;
  logic [31:0] coef_const_r;
  logic [31:0] coef_idle_lin_r;
  logic [31:0] coef_idle_sq_r;
  logic [31:0] coef_active_lin_r;
  logic [31:0] coef_active_sq_r;

  // policy state
  logic [31:0] current_tick_r;
  logic [31:0] period_start_r;
  logic [31:0] period_end_r;
  logic [31:0] active_from_r;
  logic [15:0] idle_window_r   [HISTORY_DEPTH];
  logic [15:0] active_window_r [HISTORY_DEPTH];
  logic [63:0] predicted_idle_r, predicted_idle_nxt;
  pmpu_pkg::pwr_state_t prev_state_r;

  // sequencer and serial arithmetic
  pmpu_pkg::seq_state_t seq_r, seq_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [1:0]  term_r, term_nxt;
  logic [31:0] isq_mcand_r, isq_mcand_nxt;
  logic [15:0] isq_mplier_r, isq_mplier_nxt;
  logic [31:0] isq_acc_r, isq_acc_nxt;
  logic [31:0] asq_mcand_r, asq_mcand_nxt;
  logic [15:0] asq_mplier_r, asq_mplier_nxt;
  logic [31:0] asq_acc_r, asq_acc_nxt;
  logic [63:0] mcand_r, mcand_nxt;
  logic [31:0] mplier_r, mplier_nxt;
  logic [63:0] prod_r, prod_nxt;

  // output register
  logic                 out_valid_r;
  pmpu_pkg::pwr_state_t out_state_r;
  logic [31:0]          out_tick_r;
  logic                 out_changed_r;
  logic                 out_waiting_r;
  logic                 out_last_r;

  logic        in_ready;
  logic        in_fire;
  logic        rec_fire;
  logic        tick_live;
  logic        tick_fire;
  logic [15:0] idle_len;
  logic [15:0] active_len;
  logic [1:0]  ld_term;
  logic [31:0] ld_coef;
  logic [31:0] ld_op;
  logic        term_wide;
  logic [63:0] sum;
  logic        sum_ovf;
  logic [32:0] lim_low;
  logic [32:0] lim_high;
  logic [63:0] thr_low;
  logic [63:0] thr_high;
  logic        high_ge_low;
  pmpu_pkg::pwr_state_t tick_state;

  function automatic logic [15:0] sat_dur(input logic [31:0] from, input logic [31:0] to);
    logic [31:0] d;
    d = to - from;
    if (to < from) begin
      return 16'd0;
    end else if (|d[31:16]) begin
      return 16'hFFFF;
    end else begin
      return d[15:0];
    end
  endfunction

  assign in_ready  = (seq_r == pmpu_pkg::SEQ_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_fire   = in_ch.valid && in_ready;
  assign rec_fire  = in_fire && (in_ch.func == pmpu_pkg::FUNC_RECORD);
  assign tick_live = current_tick_r < period_end_r;
  assign tick_fire = in_fire && (in_ch.func == pmpu_pkg::FUNC_TICK) && tick_live;

  assign idle_len   = sat_dur(in_ch.idle_start, in_ch.idle_end);
  assign active_len = sat_dur(active_from_r, in_ch.idle_start);

  // tick decision
  assign lim_low     = {1'b0, period_start_r} + {17'd0, level_low_r};
  assign lim_high    = {1'b0, period_start_r} + {17'd0, level_high_r};
  assign thr_low     = {24'd0, level_low_r, 24'd0};
  assign thr_high    = {24'd0, level_high_r, 24'd0};
  assign high_ge_low = level_high_r >= level_low_r;

  always_comb begin
    tick_state = pmpu_pkg::PWR_ACTIVE;
    if (!policy_mode_r) begin
      if ({1'b0, current_tick_r} > lim_low) begin
        tick_state = pmpu_pkg::PWR_IDLE;
      end
      if (high_ge_low && ({1'b0, current_tick_r} > lim_high)) begin
        tick_state = pmpu_pkg::PWR_SLEEP;
      end
    end else if (current_tick_r < period_start_r) begin
      tick_state = pmpu_pkg::PWR_ACTIVE;
    end else if ($signed(predicted_idle_r) < $signed(thr_low)) begin
      tick_state = pmpu_pkg::PWR_ACTIVE;
    end else if (($signed(predicted_idle_r) > $signed(thr_high)) && high_ge_low) begin
      tick_state = pmpu_pkg::PWR_SLEEP;
    end else begin
      tick_state = pmpu_pkg::PWR_IDLE;
    end
  end

  // operand select for the shared multiplier
  assign ld_term = (seq_r == pmpu_pkg::SEQ_SQUARE) ? pmpu_pkg::TERM_IDLE_LIN : term_r + 2'd1;

  always_comb begin
    unique case (ld_term)
      pmpu_pkg::TERM_IDLE_LIN: begin
        ld_coef = coef_idle_lin_r;
        ld_op   = {16'd0, idle_window_r[HISTORY_DEPTH-1]};
      end
      pmpu_pkg::TERM_IDLE_SQ: begin
        ld_coef = coef_idle_sq_r;
        ld_op   = isq_acc_r;
      end
      pmpu_pkg::TERM_ACTIVE_LIN: begin
        ld_coef = coef_active_lin_r;
        ld_op   = {16'd0, active_window_r[HISTORY_DEPTH-1]};
      end
      default: begin
        ld_coef = coef_active_sq_r;
        ld_op   = asq_acc_r;
      end
    endcase
  end

  assign term_wide = (term_r == pmpu_pkg::TERM_IDLE_SQ) || (term_r == pmpu_pkg::TERM_ACTIVE_SQ);
  assign sum       = predicted_idle_r + prod_r;
  assign sum_ovf   = (predicted_idle_r[63] == prod_r[63]) && (sum[63] != predicted_idle_r[63]);

  // sequencer next state and datapath
  always_comb begin
    seq_nxt            = seq_r;
    cnt_nxt            = cnt_r;
    term_nxt           = term_r;
    isq_mcand_nxt      = isq_mcand_r;
    isq_mplier_nxt     = isq_mplier_r;
    isq_acc_nxt        = isq_acc_r;
    asq_mcand_nxt      = asq_mcand_r;
    asq_mplier_nxt     = asq_mplier_r;
    asq_acc_nxt        = asq_acc_r;
    mcand_nxt          = mcand_r;
    mplier_nxt         = mplier_r;
    prod_nxt           = prod_r;
    predicted_idle_nxt = predicted_idle_r;
    unique case (seq_r)
      pmpu_pkg::SEQ_IDLE: begin
        if (rec_fire) begin
          seq_nxt            = pmpu_pkg::SEQ_SQUARE;
          cnt_nxt            = 5'd0;
          isq_mcand_nxt      = {16'd0, idle_len};
          isq_mplier_nxt     = idle_len;
          isq_acc_nxt        = 32'd0;
          asq_mcand_nxt      = {16'd0, active_len};
          asq_mplier_nxt     = active_len;
          asq_acc_nxt        = 32'd0;
          predicted_idle_nxt = {{32{coef_const_r[31]}}, coef_const_r};
        end
      end
      pmpu_pkg::SEQ_SQUARE: begin
        isq_acc_nxt    = isq_acc_r + (isq_mplier_r[0] ? isq_mcand_r : 32'd0);
        isq_mcand_nxt  = {isq_mcand_r[30:0], 1'b0};
        isq_mplier_nxt = {1'b0, isq_mplier_r[15:1]};
        asq_acc_nxt    = asq_acc_r + (asq_mplier_r[0] ? asq_mcand_r : 32'd0);
        asq_mcand_nxt  = {asq_mcand_r[30:0], 1'b0};
        asq_mplier_nxt = {1'b0, asq_mplier_r[15:1]};
        cnt_nxt        = cnt_r + 5'd1;
        if (cnt_r == pmpu_pkg::CNT_NARROW_LAST) begin
          seq_nxt    = pmpu_pkg::SEQ_MUL;
          cnt_nxt    = 5'd0;
          term_nxt   = ld_term;
          mcand_nxt  = {{32{ld_coef[31]}}, ld_coef};
          mplier_nxt = ld_op;
          prod_nxt   = 64'd0;
        end
      end
      pmpu_pkg::SEQ_MUL: begin
        prod_nxt   = prod_r + (mplier_r[0] ? mcand_r : 64'd0);
        mcand_nxt  = {mcand_r[62:0], 1'b0};
        mplier_nxt = {1'b0, mplier_r[31:1]};
        cnt_nxt    = cnt_r + 5'd1;
        if (cnt_r == (term_wide ? pmpu_pkg::CNT_WIDE_LAST : pmpu_pkg::CNT_NARROW_LAST)) begin
          seq_nxt = pmpu_pkg::SEQ_ACC;
        end
      end
      pmpu_pkg::SEQ_ACC: begin
        // saturating add to the signed 64-bit range
        if (sum_ovf) begin
          predicted_idle_nxt = predicted_idle_r[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end else begin
          predicted_idle_nxt = sum;
        end
        if (term_r == pmpu_pkg::TERM_ACTIVE_SQ) begin
          seq_nxt = pmpu_pkg::SEQ_IDLE;
        end else begin
          seq_nxt    = pmpu_pkg::SEQ_MUL;
          cnt_nxt    = 5'd0;
          term_nxt   = ld_term;
          mcand_nxt  = {{32{ld_coef[31]}}, ld_coef};
          mplier_nxt = ld_op;
          prod_nxt   = 64'd0;
        end
      end
      default: begin
        seq_nxt = pmpu_pkg::SEQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r            <= pmpu_pkg::SEQ_IDLE;
      predicted_idle_r <= 64'd0;
    end else begin
      seq_r            <= seq_nxt;
      predicted_idle_r <= predicted_idle_nxt;
    end
  end

  // serial arithmetic scratch
  always_ff @(posedge clk) begin
    cnt_r        <= cnt_nxt;
    term_r       <= term_nxt;
    isq_mcand_r  <= isq_mcand_nxt;
    isq_mplier_r <= isq_mplier_nxt;
    isq_acc_r    <= isq_acc_nxt;
    asq_mcand_r  <= asq_mcand_nxt;
    asq_mplier_r <= asq_mplier_nxt;
    asq_acc_r    <= asq_acc_nxt;
    mcand_r      <= mcand_nxt;
    mplier_r     <= mplier_nxt;
    prod_r       <= prod_nxt;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_mode_r     <= 1'b0;
      level_low_r       <= 16'd0;
      level_high_r      <= 16'd0;
      coef_const_r      <= 32'd0;
      coef_idle_lin_r   <= 32'd0;
      coef_idle_sq_r    <= 32'd0;
      coef_active_lin_r <= 32'd0;
      coef_active_sq_r  <= 32'd0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        pmpu_pkg::CFG_POLICY_MODE:     policy_mode_r     <= cfg_wdata[0];
        pmpu_pkg::CFG_LEVEL_LOW:       level_low_r       <= cfg_wdata[15:0];
        pmpu_pkg::CFG_LEVEL_HIGH:      level_high_r      <= cfg_wdata[15:0];
        pmpu_pkg::CFG_COEF_CONST:      coef_const_r      <= cfg_wdata;
        pmpu_pkg::CFG_COEF_IDLE_LIN:   coef_idle_lin_r   <= cfg_wdata;
        pmpu_pkg::CFG_COEF_IDLE_SQ:    coef_idle_sq_r    <= cfg_wdata;
        pmpu_pkg::CFG_COEF_ACTIVE_LIN: coef_active_lin_r <= cfg_wdata;
        pmpu_pkg::CFG_COEF_ACTIVE_SQ:  coef_active_sq_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // period bookkeeping, history windows and tick time
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      current_tick_r <= 32'd0;
      period_start_r <= 32'd0;
      period_end_r   <= 32'd0;
      active_from_r  <= 32'd0;
      prev_state_r   <= pmpu_pkg::PWR_ACTIVE;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        idle_window_r[i]   <= 16'd0;
        active_window_r[i] <= 16'd0;
      end
    end else if (rec_fire) begin
      period_start_r <= in_ch.idle_start;
      period_end_r   <= in_ch.idle_end;
      active_from_r  <= in_ch.idle_end;
      for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
        idle_window_r[i]   <= idle_window_r[i+1];
        active_window_r[i] <= active_window_r[i+1];
      end
      idle_window_r[HISTORY_DEPTH-1]   <= idle_len;
      active_window_r[HISTORY_DEPTH-1] <= active_len;
    end else if (tick_fire) begin
      current_tick_r <= current_tick_r + 32'd1;
      prev_state_r   <= tick_state;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (tick_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_fire) begin
      out_state_r   <= tick_state;
      out_tick_r    <= current_tick_r;
      out_changed_r <= tick_state != prev_state_r;
      out_waiting_r <= (tick_state == pmpu_pkg::PWR_ACTIVE) &&
                       (current_tick_r >= period_start_r);
      out_last_r    <= (current_tick_r + 32'd1) == period_end_r;
    end
  end

  assign in_ch.ready            = in_ready;
  assign out_ch.valid           = out_valid_r;
  assign out_ch.power_state     = out_state_r;
  assign out_ch.tick_time       = out_tick_r;
  assign out_ch.state_changed   = out_changed_r;
  assign out_ch.timeout_waiting = out_waiting_r;
  assign out_ch.period_last     = out_last_r;

endmodule

@@ sim/tb_power_mode_policy_unit.sv @@
// testbench of the power mode policy unit: directed table, then random phases against a predictor
module tb_power_mode_policy_unit;

  localparam int STALL_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 200;
  localparam int PHASES        = 10;
  localparam int PHASE_ITEMS   = 100;
  localparam int HOLD_CYCLES   = 300;
  localparam int HOLD_AFTER    = 150;

  typedef struct packed {
    pmpu_pkg::pwr_state_t state;
    logic [31:0]          tick;
    logic                 changed;
    logic                 waiting;
    logic                 last;
  } decision_t;

  typedef enum logic [1:0] {
    ROW_MODEL,
    ROW_TYPED,
    ROW_SILENT
  } row_kind_t;

  typedef struct packed {
    logic        func;
    logic [31:0] start;
    logic [31:0] stop;
    row_kind_t   kind;
    decision_t   want;
  } stim_row_t;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           cfg_wr_en;
  logic [pmpu_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [31:0]                    cfg_wdata;

  pmpu_in_if  in_if ();
  pmpu_out_if out_if ();

  power_mode_policy_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // predictor copy of the registers and the policy state
  logic                 pol_mode;
  logic [15:0]          lvl_low;
  logic [15:0]          lvl_high;
  logic signed [31:0]   k_const;
  logic signed [31:0]   k_idle_lin;
  logic signed [31:0]   k_idle_sq;
  logic signed [31:0]   k_act_lin;
  logic signed [31:0]   k_act_sq;
  logic [31:0]          now_tick;
  logic [31:0]          per_start;
  logic [31:0]          per_end;
  logic [31:0]          act_from;
  logic [15:0]          idle_hist [4];
  logic [15:0]          act_hist [4];
  longint               pred_idle;
  pmpu_pkg::pwr_state_t last_state;

  decision_t pending_decisions [$];

  int err_count    = 0;
  int results_seen = 0;
  int useful_items = 0;
  int stall_cycles = 0;
  int in_calm      = 0;
  int out_calm     = 0;
  bit held_off     = 1'b0;

  task automatic note_error(input string msg);
    err_count++;
    $display("mismatch: %s", msg);
  endtask

  function automatic int draw_gap(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) calm_left = $urandom_range(10, 40);
    return $urandom_range(0, 12);
  endfunction

  function automatic logic [15:0] clamp_span(input logic [31:0] from, input logic [31:0] upto);
    logic [31:0] d;
    d = upto - from;
    if (upto < from) return 16'd0;
    return (d > 32'h0000_FFFF) ? 16'hFFFF : d[15:0];
  endfunction

  function automatic longint add_clamped(input longint a, input longint b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s[64] != s[63]) return s[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
    return s[63:0];
  endfunction

  task automatic predictor_reset();
    pol_mode   = 1'b0;
    lvl_low    = '0;
    lvl_high   = '0;
    k_const    = '0;
    k_idle_lin = '0;
    k_idle_sq  = '0;
    k_act_lin  = '0;
    k_act_sq   = '0;
    now_tick   = '0;
    per_start  = '0;
    per_end    = '0;
    act_from   = '0;
    for (int i = 0; i < 4; i++) begin
      idle_hist[i] = '0;
      act_hist[i]  = '0;
    end
    pred_idle  = 0;
    last_state = pmpu_pkg::PWR_ACTIVE;
  endtask

  // one input transaction through the policy; produced is set when a decision comes out
  task automatic policy_step(input logic func, input logic [31:0] start, input logic [31:0] stop,
                             output bit produced, output decision_t d);
    logic [15:0]          ni;
    logic [15:0]          na;
    longint               iv;
    longint               av;
    pmpu_pkg::pwr_state_t st;
    produced = 1'b0;
    d        = '0;
    if (func == pmpu_pkg::FUNC_RECORD) begin
      ni = clamp_span(start, stop);
      na = clamp_span(act_from, start);
      for (int i = 0; i < 3; i++) begin
        idle_hist[i] = idle_hist[i+1];
        act_hist[i]  = act_hist[i+1];
      end
      idle_hist[3] = ni;
      act_hist[3]  = na;
      per_start    = start;
      per_end      = stop;
      act_from     = stop;
      iv = longint'(ni);
      av = longint'(na);
      pred_idle = longint'(k_const);
      pred_idle = add_clamped(pred_idle, longint'(k_idle_lin) * iv);
      pred_idle = add_clamped(pred_idle, longint'(k_idle_sq) * (iv * iv));
      pred_idle = add_clamped(pred_idle, longint'(k_act_lin) * av);
      pred_idle = add_clamped(pred_idle, longint'(k_act_sq) * (av * av));
    end else if (now_tick < per_end) begin
      if (pol_mode == 1'b0) begin
        st = pmpu_pkg::PWR_ACTIVE;
        if (33'(now_tick) > 33'(per_start) + 33'(lvl_low)) st = pmpu_pkg::PWR_IDLE;
        if (lvl_high >= lvl_low && 33'(now_tick) > 33'(per_start) + 33'(lvl_high))
          st = pmpu_pkg::PWR_SLEEP;
      end else if (now_tick < per_start) begin
        st = pmpu_pkg::PWR_ACTIVE;
      end else if (pred_idle < longint'({lvl_low, 24'd0})) begin
        st = pmpu_pkg::PWR_ACTIVE;
      end else if (pred_idle > longint'({lvl_high, 24'd0}) && lvl_high >= lvl_low) begin
        st = pmpu_pkg::PWR_SLEEP;
      end else begin
        st = pmpu_pkg::PWR_IDLE;
      end
      d.state    = st;
      d.tick     = now_tick;
      d.changed  = (st != last_state);
      d.waiting  = (st == pmpu_pkg::PWR_ACTIVE) && (now_tick >= per_start);
      d.last     = (33'(now_tick) + 33'd1 == 33'(per_end));
      last_state = st;
      now_tick   = now_tick + 32'd1;
      produced   = 1'b1;
    end
  endtask

  function automatic stim_row_t period_row(input logic [31:0] s, input logic [31:0] e);
    stim_row_t r;
    r       = '0;
    r.func  = pmpu_pkg::FUNC_RECORD;
    r.start = s;
    r.stop  = e;
    r.kind  = ROW_MODEL;
    return r;
  endfunction

  function automatic stim_row_t plain_tick(input row_kind_t kind);
    stim_row_t r;
    r      = '0;
    r.func = pmpu_pkg::FUNC_TICK;
    r.kind = kind;
    return r;
  endfunction

  function automatic stim_row_t typed_tick(input pmpu_pkg::pwr_state_t st, input logic [31:0] t,
                                           input logic c, input logic w, input logic l);
    stim_row_t r;
    r              = plain_tick(ROW_TYPED);
    r.want.state   = st;
    r.want.tick    = t;
    r.want.changed = c;
    r.want.waiting = w;
    r.want.last    = l;
    return r;
  endfunction

  task automatic offer(input stim_row_t row);
    int        gap;
    bit        produced;
    decision_t d;
    gap = draw_gap(in_calm);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.func       <= row.func;
    in_if.idle_start <= row.start;
    in_if.idle_end   <= row.stop;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    policy_step(row.func, row.start, row.stop, produced, d);
    if (row.kind == ROW_TYPED) pending_decisions.push_back(row.want);
    else if (row.kind == ROW_MODEL && produced) pending_decisions.push_back(d);
    if (row.func == pmpu_pkg::FUNC_RECORD || produced) useful_items++;
  endtask

  task automatic write_reg(input logic [pmpu_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      pmpu_pkg::CFG_POLICY_MODE:     pol_mode   = data[0];
      pmpu_pkg::CFG_LEVEL_LOW:       lvl_low    = data[15:0];
      pmpu_pkg::CFG_LEVEL_HIGH:      lvl_high   = data[15:0];
      pmpu_pkg::CFG_COEF_CONST:      k_const    = data;
      pmpu_pkg::CFG_COEF_IDLE_LIN:   k_idle_lin = data;
      pmpu_pkg::CFG_COEF_IDLE_SQ:    k_idle_sq  = data;
      pmpu_pkg::CFG_COEF_ACTIVE_LIN: k_act_lin  = data;
      pmpu_pkg::CFG_COEF_ACTIVE_SQ:  k_act_sq   = data;
      default: ;
    endcase
  endtask

  function automatic logic [31:0] small_coef(input int span);
    if ($urandom_range(0, 3) == 0) return $urandom;
    return $urandom_range(0, 2 * span) - span;
  endfunction

  task automatic apply_settings(input int ph);
    logic [31:0] v [8];
    case (ph)
      0: v = '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0};
      1: v = '{32'd0, 32'hFFFF, 32'hFFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
      2: v = '{32'd1, 32'd0, 32'hFFFF, 32'h8000_0000, 32'h8000_0000,
               32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
      3: v = '{32'd1, 32'hFFFF, 32'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
      4: v = '{32'd1, 32'd0, 32'd0, 32'h7FFF_FFFF, 32'd0, 32'd0, 32'd0, 32'd0};
      default: begin
        v[pmpu_pkg::CFG_POLICY_MODE]     = $urandom_range(0, 1);
        v[pmpu_pkg::CFG_LEVEL_LOW]       = $urandom_range(0, 12);
        v[pmpu_pkg::CFG_LEVEL_HIGH]      = $urandom_range(0, 24);
        // keep most predictions within a few dozen ticks so all three states show up
        v[pmpu_pkg::CFG_COEF_CONST]      = small_coef(20 << 24);
        v[pmpu_pkg::CFG_COEF_IDLE_LIN]   = small_coef(2 << 24);
        v[pmpu_pkg::CFG_COEF_IDLE_SQ]    = small_coef(1 << 19);
        v[pmpu_pkg::CFG_COEF_ACTIVE_LIN] = small_coef(2 << 24);
        v[pmpu_pkg::CFG_COEF_ACTIVE_SQ]  = small_coef(1 << 19);
      end
    endcase
    write_reg(pmpu_pkg::CFG_POLICY_MODE,     v[pmpu_pkg::CFG_POLICY_MODE]);
    write_reg(pmpu_pkg::CFG_LEVEL_LOW,       v[pmpu_pkg::CFG_LEVEL_LOW]);
    write_reg(pmpu_pkg::CFG_LEVEL_HIGH,      v[pmpu_pkg::CFG_LEVEL_HIGH]);
    write_reg(pmpu_pkg::CFG_COEF_CONST,      v[pmpu_pkg::CFG_COEF_CONST]);
    write_reg(pmpu_pkg::CFG_COEF_IDLE_LIN,   v[pmpu_pkg::CFG_COEF_IDLE_LIN]);
    write_reg(pmpu_pkg::CFG_COEF_IDLE_SQ,    v[pmpu_pkg::CFG_COEF_IDLE_SQ]);
    write_reg(pmpu_pkg::CFG_COEF_ACTIVE_LIN, v[pmpu_pkg::CFG_COEF_ACTIVE_LIN]);
    write_reg(pmpu_pkg::CFG_COEF_ACTIVE_SQ,  v[pmpu_pkg::CFG_COEF_ACTIVE_SQ]);
    cfg_wr_en <= 1'b0;
  endtask

  // a record may still be in the multiplier after the last decision has come out
  task automatic settle_block();
    in_if.valid <= 1'b0;
    while (pending_decisions.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // mostly a period record followed by enough ticks to walk through it, sometimes noise
  task automatic random_burst();
    int          pick;
    int          n;
    logic [31:0] s;
    logic [31:0] e;
    pick = $urandom_range(0, 9);
    if (pick < 8) begin
      s = now_tick + $urandom_range(0, 6);
      if (pick == 6) s = act_from - $urandom_range(1, 4);
      e = s + $urandom_range(1, 20);
      if (pick == 7) e = s - $urandom_range(1, 3);
      offer(period_row(s, e));
      n = (e > now_tick && e - now_tick < 64) ? int'(e - now_tick) : 0;
      if ($urandom_range(0, 5) == 0) n = n / 2;
      n += $urandom_range(0, 2);
    end else begin
      offer(period_row($urandom, $urandom));
      n = $urandom_range(0, 6);
    end
    repeat (n) offer(plain_tick(ROW_MODEL));
  endtask

  initial begin : stimulus
    stim_row_t directed_rows [27];
    in_if.valid      <= 1'b0;
    in_if.func       <= pmpu_pkg::FUNC_TICK;
    in_if.idle_start <= '0;
    in_if.idle_end   <= '0;
    out_if.ready     <= 1'b0;
    cfg_wr_en        <= 1'b0;
    cfg_index        <= '0;
    cfg_wdata        <= '0;
    rst_n            <= 1'b0;
    predictor_reset();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: timeout policy with both levels at zero
    directed_rows = '{
      plain_tick(ROW_SILENT),
      period_row(32'd2, 32'd5),
      typed_tick(pmpu_pkg::PWR_ACTIVE, 32'd0, 1'b0, 1'b0, 1'b0),
      typed_tick(pmpu_pkg::PWR_ACTIVE, 32'd1, 1'b0, 1'b0, 1'b0),
      typed_tick(pmpu_pkg::PWR_ACTIVE, 32'd2, 1'b0, 1'b1, 1'b0),
      typed_tick(pmpu_pkg::PWR_SLEEP,  32'd3, 1'b1, 1'b0, 1'b0),
      typed_tick(pmpu_pkg::PWR_SLEEP,  32'd4, 1'b0, 1'b0, 1'b1),
      plain_tick(ROW_SILENT),
      period_row(32'd10, 32'd7),
      typed_tick(pmpu_pkg::PWR_ACTIVE, 32'd5, 1'b1, 1'b0, 1'b0),
      typed_tick(pmpu_pkg::PWR_ACTIVE, 32'd6, 1'b0, 1'b0, 1'b1),
      plain_tick(ROW_SILENT),
      period_row(32'd3, 32'hFFFF_FFFF),
      typed_tick(pmpu_pkg::PWR_SLEEP,  32'd7, 1'b1, 1'b0, 1'b0),
      period_row(32'hFFFF_FFF0, 32'hFFFF_FFFF),
      typed_tick(pmpu_pkg::PWR_ACTIVE, 32'd8, 1'b1, 1'b0, 1'b0),
      typed_tick(pmpu_pkg::PWR_ACTIVE, 32'd9, 1'b0, 1'b0, 1'b0),
      period_row(32'd10, 32'd12),
      typed_tick(pmpu_pkg::PWR_ACTIVE, 32'd10, 1'b0, 1'b1, 1'b0),
      typed_tick(pmpu_pkg::PWR_SLEEP,  32'd11, 1'b1, 1'b0, 1'b1),
      period_row(32'd0, 32'd0),
      plain_tick(ROW_SILENT),
      period_row(32'd0, 32'd14),
      plain_tick(ROW_MODEL),
      plain_tick(ROW_MODEL),
      period_row(32'hFFFF_FFFF, 32'd0),
      plain_tick(ROW_SILENT)
    };
    foreach (directed_rows[i]) offer(directed_rows[i]);

    for (int ph = 0; ph < PHASES; ph++) begin
      settle_block();
      apply_settings(ph);
      useful_items = 0;
      while (useful_items < PHASE_ITEMS) random_burst();
    end
    settle_block();

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : decision_sink
    int        gap;
    decision_t want;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      gap = draw_gap(out_calm);
      // one long hold-off so the output register fills and the input stalls
      if (!held_off && results_seen >= HOLD_AFTER) begin
        gap      = HOLD_CYCLES;
        held_off = 1'b1;
      end
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (out_if.valid !== 1'b1);
      results_seen++;
      if (pending_decisions.size() == 0) begin
        note_error($sformatf("unexpected decision for tick %0d", out_if.tick_time));
      end else begin
        want = pending_decisions.pop_front();
        if (out_if.power_state !== want.state)
          note_error($sformatf("tick %0d: power_state %0d, expected %0d",
                               want.tick, out_if.power_state, want.state));
        if (out_if.tick_time !== want.tick)
          note_error($sformatf("tick_time %0d, expected %0d", out_if.tick_time, want.tick));
        if (out_if.state_changed !== want.changed)
          note_error($sformatf("tick %0d: state_changed %0b, expected %0b",
                               want.tick, out_if.state_changed, want.changed));
        if (out_if.timeout_waiting !== want.waiting)
          note_error($sformatf("tick %0d: timeout_waiting %0b, expected %0b",
                               want.tick, out_if.timeout_waiting, want.waiting));
        if (out_if.period_last !== want.last)
          note_error($sformatf("tick %0d: period_last %0b, expected %0b",
                               want.tick, out_if.period_last, want.last));
      end
    end
  end

  // counts cycles without any transaction on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule

@@ power_mode_policy_unit.f @@
rtl/pmpu_pkg.sv
rtl/pmpu_if.sv
rtl/power_mode_policy_unit.sv
sim/tb_power_mode_policy_unit.sv
